/* hdl/cvte_pkg.sv */
`timescale 1ns / 1ps

package cvte_pkg;

   // Encode request kinds.
   typedef enum logic [3:0] {
      OP_NULL  = 4'd0,
      OP_BOOL  = 4'd1,
      OP_UINT  = 4'd2,
      OP_SINT  = 4'd3,
      OP_F32   = 4'd4,
      OP_F64   = 4'd5,
      OP_STR   = 4'd6,
      OP_BIN   = 4'd7,
      OP_ARRAY = 4'd8,
      OP_MAP   = 4'd9,
      OP_TAG   = 4'd10,
      OP_RAW   = 4'd11
   } opcode_type;

   // Tag bytes.
   localparam logic [7:0] TAG_NIL      = 8'hc0;
   localparam logic [7:0] TAG_MARK     = 8'hc1;
   localparam logic [7:0] TAG_FALSE    = 8'hc2;
   localparam logic [7:0] TAG_TRUE     = 8'hc3;
   localparam logic [7:0] TAG_BIN8     = 8'hc4;
   localparam logic [7:0] TAG_BIN16    = 8'hc5;
   localparam logic [7:0] TAG_BIN32    = 8'hc6;
   localparam logic [7:0] TAG_F32      = 8'hca;
   localparam logic [7:0] TAG_F64      = 8'hcb;
   localparam logic [7:0] TAG_UINT8    = 8'hcc;
   localparam logic [7:0] TAG_UINT16   = 8'hcd;
   localparam logic [7:0] TAG_UINT32   = 8'hce;
   localparam logic [7:0] TAG_UINT64   = 8'hcf;
   localparam logic [7:0] TAG_INT8     = 8'hd0;
   localparam logic [7:0] TAG_INT16    = 8'hd1;
   localparam logic [7:0] TAG_INT32    = 8'hd2;
   localparam logic [7:0] TAG_INT64    = 8'hd3;
   localparam logic [7:0] TAG_STR8     = 8'hd9;
   localparam logic [7:0] TAG_STR16    = 8'hda;
   localparam logic [7:0] TAG_STR32    = 8'hdb;
   localparam logic [7:0] TAG_ARRAY16  = 8'hdc;
   localparam logic [7:0] TAG_ARRAY32  = 8'hdd;
   localparam logic [7:0] TAG_MAP16    = 8'hde;
   localparam logic [7:0] TAG_MAP32    = 8'hdf;
   localparam logic [7:0] FIX_STR      = 8'ha0;
   localparam logic [7:0] FIX_ARRAY    = 8'h90;
   localparam logic [7:0] FIX_MAP      = 8'h80;

   // Default depth of the queue between front and back.
   localparam int QUEUE_DEPTH_DEF = 2;

   // Request and result payloads.
   typedef struct packed {
      logic [3:0]  opcode;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // One classified request: optional marker byte, a head byte, then
   // nbytes little-endian payload bytes taken from data.
   typedef struct packed {
      logic        pre;
      logic [7:0]  head;
      logic [3:0]  nbytes;
      logic [63:0] data;
   } desc_type;

endpackage

/* hdl/cvte_front.sv */
`timescale 1ns / 1ps

module cvte_front
   import cvte_pkg::*;
(
   input  req_type  item,
   output desc_type desc,
   output logic     keep
);

   logic [63:0] v;
   logic        le_7f, le_ff, le_ffff, le_32b;
   logic        neg_fix, neg_8, neg_16, neg_32;

   // Range checks on the value, shared by the integer, string, binary, array and map kinds.
   always_comb begin
      v       = item.value;
      le_7f   = (v[63:7] == '0);
      le_ff   = (v[63:8] == '0);
      le_ffff = (v[63:16] == '0);
      le_32b  = (v[63:32] == '0);
      neg_fix = (v[63:5] == '1);
      neg_8   = (v[63:7] == '1);
      neg_16  = (v[63:15] == '1);
      neg_32  = (v[63:31] == '1);
   end

   // Classify the request into a marker, a head byte and a payload length.
   always_comb begin
      keep        = 1'b1;
      desc.pre    = 1'b0;
      desc.head   = TAG_NIL;
      desc.nbytes = 4'd0;
      desc.data   = v;
      unique case (opcode_type'(item.opcode))
         OP_NULL: desc.head = TAG_NIL;
         OP_BOOL: desc.head = (v != '0) ? TAG_TRUE : TAG_FALSE;
         OP_UINT, OP_SINT: begin
            if (!v[63] || opcode_type'(item.opcode) == OP_UINT) begin
               if (le_7f) begin
                  desc.head = v[7:0];
               end else if (le_ff) begin
                  desc.head = TAG_UINT8;  desc.nbytes = 4'd1;
               end else if (le_ffff) begin
                  desc.head = TAG_UINT16; desc.nbytes = 4'd2;
               end else if (le_32b) begin
                  desc.head = TAG_UINT32; desc.nbytes = 4'd4;
               end else begin
                  desc.head = TAG_UINT64; desc.nbytes = 4'd8;
               end
            end else if (neg_fix) begin
               desc.head = v[7:0];
            end else if (neg_8) begin
               desc.head = TAG_INT8;  desc.nbytes = 4'd1;
            end else if (neg_16) begin
               desc.head = TAG_INT16; desc.nbytes = 4'd2;
            end else if (neg_32) begin
               desc.head = TAG_INT32; desc.nbytes = 4'd4;
            end else begin
               desc.head = TAG_INT64; desc.nbytes = 4'd8;
            end
         end
         OP_F32: begin
            desc.head = TAG_F32; desc.nbytes = 4'd4;
         end
         OP_F64: begin
            desc.head = TAG_F64; desc.nbytes = 4'd8;
         end
         OP_STR, OP_TAG: begin
            desc.pre = (opcode_type'(item.opcode) == OP_TAG);
            if (v[63:5] == '0) begin
               desc.head = FIX_STR | {3'b000, v[4:0]};
            end else if (le_ff) begin
               desc.head = TAG_STR8;  desc.nbytes = 4'd1;
            end else if (le_ffff) begin
               desc.head = TAG_STR16; desc.nbytes = 4'd2;
            end else begin
               desc.head = TAG_STR32; desc.nbytes = 4'd4;
            end
         end
         OP_BIN: begin
            if (le_ff) begin
               desc.head = TAG_BIN8;  desc.nbytes = 4'd1;
            end else if (le_ffff) begin
               desc.head = TAG_BIN16; desc.nbytes = 4'd2;
            end else begin
               desc.head = TAG_BIN32; desc.nbytes = 4'd4;
            end
         end
         OP_ARRAY, OP_MAP: begin
            if (v[63:4] == '0) begin
               desc.head = ((opcode_type'(item.opcode) == OP_ARRAY) ? FIX_ARRAY : FIX_MAP)
                           | {4'b0000, v[3:0]};
            end else if (le_ffff) begin
               desc.head   = (opcode_type'(item.opcode) == OP_ARRAY) ? TAG_ARRAY16 : TAG_MAP16;
               desc.nbytes = 4'd2;
            end else begin
               desc.head   = (opcode_type'(item.opcode) == OP_ARRAY) ? TAG_ARRAY32 : TAG_MAP32;
               desc.nbytes = 4'd4;
            end
         end
         OP_RAW: desc.head = v[7:0];
         // Unused kinds produce no bytes at all.
         default: keep = 1'b0;
      endcase
   end

endmodule

/* hdl/cvte_queue.sv */
`timescale 1ns / 1ps

module cvte_queue
   import cvte_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output desc_type head
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   desc_type            slot_ff [DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == FullCnt);
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset) count_ff <= FullCnt)
      else $error("Queue fill count exceeds its depth.");
   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("Queue fill count did not grow on a push.");
`endif

endmodule

/* hdl/cvte_back.sv */
`timescale 1ns / 1ps

module cvte_back
   import cvte_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     head_valid,
   input  desc_type head,
   output logic     head_pop,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

   logic [3:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;
   logic [3:0] total;
   logic [3:0] pay_idx;
   logic       load;
   logic       is_last;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign total     = {3'b000, head.pre} + 4'd1 + head.nbytes;
   assign load      = head_valid && (!out_valid_ff || rsp_pop);
   assign is_last   = (idx_ff == total - 4'd1);
   assign head_pop  = load && is_last;
   assign pay_idx   = idx_ff - {3'b000, head.pre} - 4'd1;

   // Pick the byte at the current position of the request.
   always_comb begin
      out_in.last = is_last;
      if (head.pre && idx_ff == 4'd0) begin
         out_in.out_byte = TAG_MARK;
      end else if (idx_ff == {3'b000, head.pre}) begin
         out_in.out_byte = head.head;
      end else begin
         out_in.out_byte = head.data[{pay_idx[2:0], 3'b000} +: 8];
      end
   end

   // Byte position and output register control.
   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         idx_in       = is_last ? 4'd0 : idx_ff + 4'd1;
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset) (idx_ff != 4'd0) |-> head_valid)
      else $error("Byte position is mid-request with no request at the queue head.");
   assert property (@(posedge clock) disable iff (reset) head_valid |-> (idx_ff < total))
      else $error("Byte position runs past the end of the request.");
   assert property (@(posedge clock) disable iff (reset) head_pop |=> (idx_ff == 4'd0))
      else $error("Byte position did not restart after the last byte.");
`endif

endmodule

/* hdl/compact_value_tag_encoder.sv */
`timescale 1ns / 1ps

// Encodes one typed value per request into a MessagePack-style byte stream
// with little-endian payloads, one byte per result, the final byte of each
// request flagged by last. A request yields one to nine bytes, and the output
// side delivers one byte per cycle while the receiver keeps popping, so a
// request holds the byte sequencer until all its bytes are sent; one-byte
// requests run at one per cycle under that condition. A first byte passes
// through a queue slot and the output register before the result ports.
// The front classifies each request as it arrives and parks it in a small
// queue (QUEUE_DEPTH entries), so new requests are taken while a long
// encoding is still being sent; unused opcodes are taken, producing nothing.
module compact_value_tag_encoder
   import cvte_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   desc_type front_desc;
   desc_type head;
   logic     front_keep;
   logic     head_valid;
   logic     head_pop;

   // Classify each incoming request.
   cvte_front u_front (
      .item (req_data),
      .desc (front_desc),
      .keep (front_keep)
   );

   // Requests wait here between the front and the byte sequencer.
   cvte_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push && front_keep),
      .push_data  (front_desc),
      .full       (req_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // Send the bytes of the request at the queue head.
   cvte_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

/* bench/tb_compact_value_tag_encoder.sv */
`timescale 1ns / 1ps

import cvte_pkg::*;

// Scoreboard: turns each accepted request into the byte sequence it must
// produce and checks every delivered byte against the oldest one waiting.
class byte_stream_scoreboard;
   rsp_type     expected_bytes[$];
   logic [7:0]  encoding[$];
   int unsigned mismatches;
   int unsigned requests;
   int unsigned silent_requests;
   int unsigned bytes_checked;

   function new();
      mismatches      = 0;
      requests        = 0;
      silent_requests = 0;
      bytes_checked   = 0;
   endfunction

   // Appends the low n bytes of v, least significant first.
   function void put_le(logic [63:0] v, int n);
      int i;
      for (i = 0; i < n; i++) begin
         encoding.push_back(v[8*i +: 8]);
      end
   endfunction

   // Unsigned integer in the smallest form that holds it.
   function void put_uint(logic [63:0] v);
      if (v <= 64'h7f) begin
         encoding.push_back(v[7:0]);
      end else if (v <= 64'hff) begin
         encoding.push_back(TAG_UINT8);
         put_le(v, 1);
      end else if (v <= 64'hffff) begin
         encoding.push_back(TAG_UINT16);
         put_le(v, 2);
      end else if (v <= 64'hffff_ffff) begin
         encoding.push_back(TAG_UINT32);
         put_le(v, 4);
      end else begin
         encoding.push_back(TAG_UINT64);
         put_le(v, 8);
      end
   endfunction

   // Signed integer; non-negative values share the unsigned forms.
   function void put_sint(logic [63:0] v);
      if (!v[63]) begin
         put_uint(v);
      end else if (v >= 64'hffff_ffff_ffff_ffe0) begin
         encoding.push_back(v[7:0]);
      end else if (v >= 64'hffff_ffff_ffff_ff80) begin
         encoding.push_back(TAG_INT8);
         put_le(v, 1);
      end else if (v >= 64'hffff_ffff_ffff_8000) begin
         encoding.push_back(TAG_INT16);
         put_le(v, 2);
      end else if (v >= 64'hffff_ffff_8000_0000) begin
         encoding.push_back(TAG_INT32);
         put_le(v, 4);
      end else begin
         encoding.push_back(TAG_INT64);
         put_le(v, 8);
      end
   endfunction

   // String header: fixed form up to 31, then 8, 16 and 32-bit lengths.
   function void put_str_header(logic [63:0] n);
      if (n <= 64'd31) begin
         encoding.push_back(FIX_STR | n[7:0]);
      end else if (n <= 64'hff) begin
         encoding.push_back(TAG_STR8);
         put_le(n, 1);
      end else if (n <= 64'hffff) begin
         encoding.push_back(TAG_STR16);
         put_le(n, 2);
      end else begin
         encoding.push_back(TAG_STR32);
         put_le(n, 4);
      end
   endfunction

   // Array and map headers: fixed form up to 15, then 16 and 32-bit counts.
   function void put_count_header(logic [63:0] n, logic [7:0] fix_base,
                                  logic [7:0] tag16, logic [7:0] tag32);
      if (n <= 64'd15) begin
         encoding.push_back(fix_base | n[7:0]);
      end else if (n <= 64'hffff) begin
         encoding.push_back(tag16);
         put_le(n, 2);
      end else begin
         encoding.push_back(tag32);
         put_le(n, 4);
      end
   endfunction

   // Predicts the bytes of one accepted request and queues them.
   function void note_request(req_type r);
      int i;
      encoding.delete();
      case (opcode_type'(r.opcode))
         OP_NULL:  encoding.push_back(TAG_NIL);
         OP_BOOL:  encoding.push_back((r.value != 64'd0) ? TAG_TRUE : TAG_FALSE);
         OP_UINT:  put_uint(r.value);
         OP_SINT:  put_sint(r.value);
         OP_F32: begin
            encoding.push_back(TAG_F32);
            put_le(r.value, 4);
         end
         OP_F64: begin
            encoding.push_back(TAG_F64);
            put_le(r.value, 8);
         end
         OP_STR:   put_str_header(r.value);
         OP_BIN: begin
            if (r.value <= 64'hff) begin
               encoding.push_back(TAG_BIN8);
               put_le(r.value, 1);
            end else if (r.value <= 64'hffff) begin
               encoding.push_back(TAG_BIN16);
               put_le(r.value, 2);
            end else begin
               encoding.push_back(TAG_BIN32);
               put_le(r.value, 4);
            end
         end
         OP_ARRAY: put_count_header(r.value, FIX_ARRAY, TAG_ARRAY16, TAG_ARRAY32);
         OP_MAP:   put_count_header(r.value, FIX_MAP, TAG_MAP16, TAG_MAP32);
         OP_TAG: begin
            encoding.push_back(TAG_MARK);
            put_str_header(r.value);
         end
         OP_RAW:   encoding.push_back(r.value[7:0]);
         default: begin
            // Unused opcodes are taken and produce nothing.
         end
      endcase
      requests++;
      if (encoding.size() == 0) begin
         silent_requests++;
      end
      for (i = 0; i < encoding.size(); i++) begin
         expected_bytes.push_back('{out_byte: encoding[i],
                                    last: (i == encoding.size() - 1)});
      end
   endfunction

   // Compares one delivered byte with the oldest expected one.
   function void check_byte(rsp_type got);
      rsp_type want;
      if (expected_bytes.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected byte: expected none, actual byte %02h last %0b",
                  $time, got.out_byte, got.last);
         return;
      end
      want = expected_bytes.pop_front();
      bytes_checked++;
      if (got.out_byte !== want.out_byte) begin
         mismatches++;
         $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                  $time, want.out_byte, got.out_byte);
      end
      if (got.last !== want.last) begin
         mismatches++;
         $display("%0t: last mismatch on byte %02h: expected %0b, actual %0b",
                  $time, want.out_byte, want.last, got.last);
      end
   endfunction
endclass

module tb_compact_value_tag_encoder;
   import cvte_pkg::*;

   localparam int RANDOM_ITEMS   = 190;
   localparam int TAIL_CYCLES    = 16;
   localparam int WATCHDOG_LIMIT = 4000;

   // Values on and next to the size thresholds of every form.
   localparam logic [63:0] EDGES [12] = '{
      64'h0, 64'h0f, 64'h1f, 64'h7f, 64'hff, 64'hffff, 64'hffff_ffff,
      64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffe0,
      64'hffff_ffff_ffff_ff80, 64'hffff_ffff_ffff_8000,
      64'hffff_ffff_8000_0000
   };

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   logic    req_full;
   req_type req_data  = '0;
   logic    rsp_empty;
   logic    rsp_pop   = 1'b0;
   rsp_type rsp_data;

   logic    req_fire;
   logic    rsp_fire;
   logic [15:0] rx_cycle = '0;
   bit      rx_drain = 1'b0;
   int      idle_count = 0;

   byte_stream_scoreboard sb;
   req_type item;
   int      sent;
   int      burst;
   bit      drained;

   compact_value_tag_encoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   assign req_fire = req_push && !req_full;
   assign rsp_fire = rsp_pop && !rsp_empty;

   // Receiver: cycles through steady, random, every-fourth and sparse popping.
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 16'd1;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (rx_drain) begin
         rsp_pop <= 1'b1;
      end else begin
         case (rx_cycle[8:7])
            2'd0: rsp_pop <= 1'b1;
            2'd1: rsp_pop <= 1'($urandom_range(0, 1));
            2'd2: rsp_pop <= (rx_cycle[1:0] == 2'b00);
            default: rsp_pop <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Monitor: records accepted requests, checks delivered bytes, and stops
   // the run if nothing moves for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_fire) begin
            sb.note_request(req_data);
         end
         if (rsp_fire) begin
            sb.check_byte(rsp_data);
         end
         if (req_fire || rsp_fire) begin
            idle_count <= 0;
         end else if (idle_count >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog: no item moved for %0d cycles", $time, idle_count);
            $display("TB_ERROR");
            $finish;
         end else begin
            idle_count <= idle_count + 1;
         end
      end
   end

   // Offers one request and holds it until the block takes it.
   task automatic send_item(input logic [3:0] op, input logic [63:0] val);
      req_push <= 1'b1;
      req_data <= '{opcode: op, value: val};
      do @(posedge clock); while (req_full);
   endtask

   // Drops the request line and waits before the next request; n is at least one.
   task automatic hold_off(input int n);
      req_push <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic logic [63:0] random_value();
      logic [63:0] v;
      case ($urandom_range(0, 4))
         0: v = 64'($urandom_range(0, 40));
         1: v = EDGES[$urandom_range(0, 11)] + 64'($urandom_range(0, 2)) - 64'd1;
         2: v = {$urandom, $urandom} >> $urandom_range(0, 63);
         3: v = ~({$urandom, $urandom} >> $urandom_range(1, 63));
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   // Mostly real value kinds, with a few unused opcodes mixed in.
   function automatic req_type random_request();
      req_type r;
      if ($urandom_range(0, 99) < 5) begin
         r.opcode = 4'($urandom_range(12, 15));
      end else begin
         r.opcode = 4'($urandom_range(0, 11));
      end
      r.value = random_value();
      return r;
   endfunction

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed requests: every kind and some of the edges between its forms.
      send_item(OP_NULL,  64'h0);
      send_item(OP_BOOL,  64'h0);
      send_item(OP_BOOL,  64'h8000_0000_0000_0000);
      send_item(OP_UINT,  64'h7f);
      send_item(OP_UINT,  64'h80);
      send_item(OP_UINT,  64'hffff);
      send_item(OP_UINT,  64'h1_0000_0000);
      send_item(OP_UINT,  64'hffff_ffff_ffff_ffff);
      send_item(OP_SINT,  64'hffff_ffff_ffff_ffe0);
      send_item(OP_SINT,  64'hffff_ffff_ffff_ffdf);
      send_item(OP_SINT,  64'hffff_ffff_ffff_ff7f);
      send_item(OP_SINT,  64'hffff_ffff_ffff_7fff);
      send_item(OP_SINT,  64'hffff_ffff_7fff_ffff);
      send_item(OP_SINT,  64'h8000_0000_0000_0000);
      send_item(OP_F32,   64'hdead_beef_3f80_0000);
      send_item(OP_F64,   64'h0123_4567_89ab_cdef);
      send_item(OP_STR,   64'h1f);
      send_item(OP_STR,   64'h20);
      send_item(OP_STR,   64'hffff_ffff_0001_0000);
      send_item(OP_BIN,   64'h0);
      send_item(OP_BIN,   64'h100);
      send_item(OP_ARRAY, 64'hf);
      send_item(OP_MAP,   64'h1_0000);
      send_item(OP_TAG,   64'h64);
      send_item(OP_RAW,   64'hffff_ffff_ffff_ff5a);
      send_item(4'hf,     64'hffff_ffff_ffff_ffff);
      hold_off(3);

      // Random requests in bursts, with one full drain halfway through.
      sent    = 0;
      drained = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                             : $urandom_range(1, 8);
         repeat (burst) begin
            item = random_request();
            send_item(item.opcode, item.value);
            if (item.opcode <= OP_RAW) begin
               sent++;
            end
         end
         if (!drained && sent >= RANDOM_ITEMS / 2) begin
            req_push <= 1'b0;
            while (sb.expected_bytes.size() != 0) @(posedge clock);
            repeat (TAIL_CYCLES) @(posedge clock);
            drained = 1'b1;
         end else begin
            hold_off($urandom_range(1, 8));
         end
      end

      // Let everything drain, then keep watching for stray bytes.
      req_push <= 1'b0;
      rx_drain = 1'b1;
      while (sb.expected_bytes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d with unused opcodes), checked %0d result bytes.",
               sb.requests, sb.silent_requests, sb.bytes_checked);
      $display("Traffic mixed bursts and gaps, one full drain and four pop patterns.");
      if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
